### src/point_in_polygon_test_macros.svh
// ----------------------------------------------------------------------------
// Point-in-polygon test: assertion macros
// Shared concurrent assertion forms for the point-in-polygon block.
// ----------------------------------------------------------------------------
`ifndef POINT_IN_POLYGON_TEST_MACROS_SVH
`define POINT_IN_POLYGON_TEST_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define PIP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define PIP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### src/pip_pkg.sv
// ----------------------------------------------------------------------------
// Point-in-polygon package
// Field widths, item kind codes and the control word of the shared multiplier.
// ----------------------------------------------------------------------------
package pip_pkg;

	localparam int CFG_W   = 7;
	localparam int IDX_W   = 6;
	localparam int FIELD_W = 32;

	localparam logic KIND_WRITE = 1'b0;
	localparam logic KIND_QUERY = 1'b1;

	// One step of the multiply-accumulate unit
	typedef struct packed {
		logic valid;
		logic first;
		logic shift;
		logic sub;
	} mac_ctl_t;

endpackage

### src/pip_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module pip_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

### src/pip_mac.sv
// ----------------------------------------------------------------------------
// Shared multiply-accumulate unit
// Signed operand times an unsigned half-word, registered, then added to or
// subtracted from a wide accumulator, optionally shifted up by one half-word.
// ----------------------------------------------------------------------------
module pip_mac #(
	parameter int OPW = 33,
	parameter int HW  = 17,
	parameter int ACW = 67
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  pip_pkg::mac_ctl_t     ctl,
	input  logic signed [OPW-1:0] mcand,
	input  logic [HW-1:0]         mplier,
	output logic                  acc_neg
);

	localparam int PW = OPW + HW + 1;

	logic signed [PW-1:0]  prod_c;
	logic signed [PW-1:0]  prod_s1;
	pip_pkg::mac_ctl_t     ctl_s1;
	logic signed [ACW-1:0] ext;
	logic signed [ACW-1:0] term;
	logic signed [ACW-1:0] base;
	logic signed [ACW-1:0] acc_q;

	assign prod_c = mcand * $signed({1'b0, mplier});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else begin
			ctl_s1 <= ctl;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= prod_c;
		if (ctl_s1.valid) begin
			acc_q <= ctl_s1.sub ? (base - term) : (base + term);
		end
	end

	always_comb begin
		ext  = ACW'(prod_s1);
		term = ctl_s1.shift ? (ext <<< HW) : ext;
		base = ctl_s1.first ? '0 : acc_q;
	end

	assign acc_neg = acc_q[ACW-1];

endmodule

### src/point_in_polygon_test.sv
// ----------------------------------------------------------------------------
// Point-in-polygon test
// Vertex table plus an even-odd ray crossing test with exact fixed-point
// edge intersection.
// ----------------------------------------------------------------------------
// The block holds up to MAX_VERTICES polygon vertices in a RAM and answers
// inside/outside queries by the even-odd crossing rule over every edge,
// including the closing edge from the last vertex back to the first. A write
// item (kind 0) stores x/y at vertex_index, leaves the block idle and gives no
// result; a write whose index is at or above the vertex count is dropped. A
// query item (kind 1) gives one is_inside flag. The vertex count register
// (values above MAX_VERTICES act as MAX_VERTICES) is written through
// cfg_wr_en/cfg_wr_data; the user must write it only while the block is idle,
// which the block itself does not enforce. A count of zero gives outside.
// Coordinates are the low COORD_BITS bits of each field, two's complement.
// A query keeps the block busy, with item_ready low, from acceptance until
// the flag is registered. The single RAM read port gives one vertex per cycle
// while no straddling edge is under test, and the one shared multiplier forms
// the exact cross-multiplied x test of a straddling edge as four partial
// products, then an accumulate step and a decide step. The result waits in an
// output register, so a new item is taken while the previous flag is still
// unclaimed; a query that finishes before that flag is taken holds in its last
// step until it is. The vertex RAM is not cleared; queries must only touch
// vertices that have been written.
// ----------------------------------------------------------------------------
`include "point_in_polygon_test_macros.svh"

module point_in_polygon_test #(
	parameter int MAX_VERTICES = 64,
	parameter int COORD_BITS   = 32
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_wr_en,
	input  logic [pip_pkg::CFG_W-1:0]          cfg_wr_data,
	input  logic                               item_valid,
	output logic                               item_ready,
	input  logic                               kind,
	input  logic [pip_pkg::IDX_W-1:0]          vertex_index,
	input  logic signed [pip_pkg::FIELD_W-1:0] x_coord,
	input  logic signed [pip_pkg::FIELD_W-1:0] y_coord,
	output logic                               result_valid,
	input  logic                               result_ready,
	output logic                               is_inside
);

	localparam int C     = COORD_BITS;
	localparam int RAW   = $clog2(MAX_VERTICES);
	localparam int CNT_B = $clog2(MAX_VERTICES + 1);
	localparam int CW    = (CNT_B > pip_pkg::CFG_W) ? CNT_B : pip_pkg::CFG_W;
	localparam int DW    = C + 1;
	localparam int HW    = (DW + 1) / 2;
	localparam int ACW   = 2 * C + 3;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PRIME,
		ST_EDGE,
		ST_MUL0,
		ST_MUL1,
		ST_MUL2,
		ST_MUL3,
		ST_FLUSH,
		ST_TEST,
		ST_DONE
	} state_t;

	state_t                   state_q;
	logic [pip_pkg::CFG_W-1:0] vertex_count_q;
	logic [CW-1:0]            eff_count;
	logic [CW-1:0]            vc_ext;
	logic [CW-1:0]            idx_ext;
	logic [CW-1:0]            n_q;
	logic [CW-1:0]            ptr_q;
	logic [CW-1:0]            rd_addr_full;
	logic                     accept;
	logic                     query_start;
	logic                     edge_last;
	logic                     last_q;
	logic                     inside_q;
	logic                     result_valid_q;
	logic                     is_inside_q;
	logic                     mac_busy;
	logic                     in_done;

	// vertex RAM ports
	logic                     ram_wr_en;
	logic [RAW-1:0]           ram_wr_addr;
	logic [2*C-1:0]           ram_wr_data;
	logic                     ram_rd_en;
	logic [RAW-1:0]           ram_rd_addr;
	logic [2*C-1:0]           ram_rd_data;

	// query point and previous vertex
	logic signed [C-1:0]      px_q;
	logic signed [C-1:0]      py_q;
	logic signed [C-1:0]      prev_x_q;
	logic signed [C-1:0]      prev_y_q;
	logic signed [C-1:0]      cur_x;
	logic signed [C-1:0]      cur_y;

	// edge arithmetic
	logic                     crosses;
	logic signed [DW-1:0]     dy;
	logic signed [DW-1:0]     ty;
	logic signed [DW-1:0]     ax;
	logic signed [DW-1:0]     cx;
	logic [DW-1:0]            dy_mag;
	logic [DW-1:0]            ty_mag;
	logic signed [DW-1:0]     a_op_q;
	logic signed [DW-1:0]     c_op_q;
	logic [2*HW-1:0]          b_mag_q;
	logic [2*HW-1:0]          d_mag_q;

	// shared multiplier
	pip_pkg::mac_ctl_t        mac_ctl;
	logic signed [DW-1:0]     mac_mcand;
	logic [HW-1:0]            mac_mplier;
	logic                     acc_neg;

	// ---------------------------------------------------------------- config
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vertex_count_q <= '0;
		end else if (cfg_wr_en) begin
			vertex_count_q <= cfg_wr_data;
		end
	end

	// Clamp the count to the table size
	assign vc_ext    = CW'(vertex_count_q);
	assign eff_count = (vc_ext > CW'(MAX_VERTICES)) ? CW'(MAX_VERTICES) : vc_ext;

	// ---------------------------------------------------------------- input side
	assign item_ready  = (state_q == ST_IDLE);
	assign accept      = item_valid && item_ready;
	assign query_start = accept && (kind == pip_pkg::KIND_QUERY);

	// Writes go straight into the RAM; drop those beyond the vertex count
	assign idx_ext     = CW'(vertex_index);
	assign ram_wr_en   = accept && (kind == pip_pkg::KIND_WRITE) && (idx_ext < eff_count);
	assign ram_wr_addr = idx_ext[RAW-1:0];
	assign ram_wr_data = {x_coord[C-1:0], y_coord[C-1:0]};

	// Read order: last vertex first, then 0 .. n-1, so every fresh read is
	// vertex a of an edge whose vertex b is the one read before it.
	assign edge_last = (ptr_q == n_q);

	always_comb begin
		ram_rd_en    = 1'b0;
		rd_addr_full = ptr_q;
		if (state_q == ST_IDLE) begin
			ram_rd_en    = query_start && (eff_count != '0);
			rd_addr_full = eff_count - CW'(1);
		end else if (state_q == ST_PRIME) begin
			ram_rd_en = 1'b1;
		end else if (state_q == ST_EDGE) begin
			ram_rd_en = !edge_last;
		end
	end

	assign ram_rd_addr = rd_addr_full[RAW-1:0];

	pip_ram #(
		.WIDTH (2 * C),
		.DEPTH (MAX_VERTICES)
	) u_vertex_ram (
		.clk     (clk),
		.wr_en   (ram_wr_en),
		.wr_addr (ram_wr_addr),
		.wr_data (ram_wr_data),
		.rd_en   (ram_rd_en),
		.rd_addr (ram_rd_addr),
		.rd_data (ram_rd_data)
	);

	assign cur_x = ram_rd_data[2*C-1:C];
	assign cur_y = ram_rd_data[C-1:0];

	// ---------------------------------------------------------------- edge test
	// The edge straddles the ray when one end is at or below the query y and
	// the other above it. Then x test: (px - xa)*|dy| < (xb - xa)*|py - ya|.
	always_comb begin
		crosses = ((cur_y <= py_q) && (py_q < prev_y_q)) ||
		          ((prev_y_q <= py_q) && (py_q < cur_y));
		dy      = DW'(prev_y_q) - DW'(cur_y);
		ty      = DW'(py_q) - DW'(cur_y);
		ax      = DW'(px_q) - DW'(cur_x);
		cx      = DW'(prev_x_q) - DW'(cur_x);
		dy_mag  = dy[DW-1] ? DW'(-dy) : DW'(dy);
		ty_mag  = ty[DW-1] ? DW'(-ty) : DW'(ty);
	end

	// Hold query point, previous vertex and the operands of the x test
	always_ff @(posedge clk) begin
		if (query_start) begin
			px_q <= x_coord[C-1:0];
			py_q <= y_coord[C-1:0];
		end
		if (state_q == ST_PRIME || state_q == ST_EDGE) begin
			prev_x_q <= cur_x;
			prev_y_q <= cur_y;
		end
		if (state_q == ST_EDGE) begin
			a_op_q  <= ax;
			c_op_q  <= cx;
			b_mag_q <= (2*HW)'(dy_mag);
			d_mag_q <= (2*HW)'(ty_mag);
		end
	end

	// ---------------------------------------------------------------- multiplier
	// Four partial products: +a*b_lo, +a*b_hi<<HW, -c*d_lo, -c*d_hi<<HW.
	always_comb begin
		mac_ctl    = '0;
		mac_mcand  = a_op_q;
		mac_mplier = b_mag_q[HW-1:0];
		unique case (state_q)
			ST_MUL0: begin
				mac_ctl.valid = 1'b1;
				mac_ctl.first = 1'b1;
			end
			ST_MUL1: begin
				mac_ctl.valid = 1'b1;
				mac_ctl.shift = 1'b1;
				mac_mplier    = b_mag_q[2*HW-1:HW];
			end
			ST_MUL2: begin
				mac_ctl.valid = 1'b1;
				mac_ctl.sub   = 1'b1;
				mac_mcand     = c_op_q;
				mac_mplier    = d_mag_q[HW-1:0];
			end
			ST_MUL3: begin
				mac_ctl.valid = 1'b1;
				mac_ctl.shift = 1'b1;
				mac_ctl.sub   = 1'b1;
				mac_mcand     = c_op_q;
				mac_mplier    = d_mag_q[2*HW-1:HW];
			end
			default: begin
				mac_ctl = '0;
			end
		endcase
	end

	pip_mac #(
		.OPW (DW),
		.HW  (HW),
		.ACW (ACW)
	) u_mac (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (mac_ctl),
		.mcand   (mac_mcand),
		.mplier  (mac_mplier),
		.acc_neg (acc_neg)
	);

	// ---------------------------------------------------------------- sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			n_q            <= '0;
			ptr_q          <= '0;
			last_q         <= 1'b0;
			inside_q       <= 1'b0;
			result_valid_q <= 1'b0;
			is_inside_q    <= 1'b0;
		end else begin
			// the done step refills the output register itself
			if (result_valid_q && result_ready && state_q != ST_DONE) begin
				result_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (query_start) begin
						n_q      <= eff_count;
						ptr_q    <= '0;
						inside_q <= 1'b0;
						state_q  <= (eff_count == '0) ? ST_DONE : ST_PRIME;
					end
				end
				ST_PRIME: begin
					ptr_q   <= ptr_q + CW'(1);
					state_q <= ST_EDGE;
				end
				ST_EDGE: begin
					if (!edge_last) begin
						ptr_q <= ptr_q + CW'(1);
					end
					last_q <= edge_last;
					if (crosses) begin
						state_q <= ST_MUL0;
					end else if (edge_last) begin
						state_q <= ST_DONE;
					end
				end
				ST_MUL0:  state_q <= ST_MUL1;
				ST_MUL1:  state_q <= ST_MUL2;
				ST_MUL2:  state_q <= ST_MUL3;
				ST_MUL3:  state_q <= ST_FLUSH;
				ST_FLUSH: state_q <= ST_TEST;
				ST_TEST: begin
					// toggle on a negative difference: query x left of the edge
					if (acc_neg) begin
						inside_q <= !inside_q;
					end
					state_q <= last_q ? ST_DONE : ST_EDGE;
				end
				ST_DONE: begin
					if (!result_valid_q || result_ready) begin
						result_valid_q <= 1'b1;
						is_inside_q    <= inside_q;
						state_q        <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign result_valid = result_valid_q;
	assign is_inside    = is_inside_q;

	// ---------------------------------------------------------------- checks
	assign mac_busy = (state_q == ST_MUL0) || (state_q == ST_MUL1) || (state_q == ST_MUL2) ||
	                  (state_q == ST_MUL3) || (state_q == ST_FLUSH) || (state_q == ST_TEST);
	assign in_done  = (state_q == ST_DONE);

	`PIP_ASSERT_NOW(a_no_read_in_mac, clk, arst_n, mac_busy, !ram_rd_en, "read during multiply")
	`PIP_ASSERT_NEXT(a_query_busy, clk, arst_n, query_start, !item_ready, "ready after a query")
	`PIP_ASSERT_NOW(a_ptr_bound, clk, arst_n, state_q != ST_IDLE, ptr_q <= n_q, "pointer past count")
	`PIP_ASSERT_NOW(a_result_from_done, clk, arst_n, $rose(result_valid), $past(in_done), "early flag")

endmodule
